/* rtl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, constants and hash functions of the open-addressing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned SIZE_W      = ADDR_W + 1;
    localparam int unsigned KEY_DIGITS  = 16;
    localparam int unsigned KEY_W       = 4 * KEY_DIGITS;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned VALUE_BITS  = 32;
    localparam int unsigned OUT_VAL_W   = 32;
    localparam int unsigned CHUNK_DIGITS = 7;
    localparam int unsigned HASH_W      = 4 * CHUNK_DIGITS;
    localparam int unsigned PROBE_W     = 21;
    localparam int unsigned N_CHUNKS    = (KEY_DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_TOTAL  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY_KEY  = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_NO_INSERT  = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } t_status;

    typedef struct packed {
        logic                  used;
        logic [LEN_W-1:0]      len;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    // Mask of the low n digits of a key
    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        if (n >= LEN_W'(KEY_DIGITS)) begin
            m = '1;
        end else begin
            m = (KEY_W'(1) << (n * 4)) - KEY_W'(1);
        end
        return m;
    endfunction

    function automatic logic [HASH_W-1:0] hash_mask(input logic [LEN_W-1:0] n);
        logic [HASH_W-1:0] m;
        m = (HASH_W'(1) << (n * 4)) - HASH_W'(1);
        return m;
    endfunction

    // Rightmost seven digits
    function automatic logic [HASH_W-1:0] hash_tail(input logic [KEY_W-1:0] key,
                                                   input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = (len < LEN_W'(CHUNK_DIGITS)) ? len : LEN_W'(CHUNK_DIGITS);
        return key[HASH_W-1:0] & hash_mask(n);
    endfunction

    // XOR of seven-digit chunks taken from the left
    function automatic logic [HASH_W-1:0] hash_chunks(input logic [KEY_W-1:0] key,
                                                     input logic [LEN_W-1:0] len);
        logic [HASH_W-1:0] acc;
        logic [LEN_W-1:0]  p;
        logic [LEN_W-1:0]  left;
        logic [LEN_W-1:0]  n;
        logic [KEY_W-1:0]  sh;
        acc = '0;
        for (int k = 0; k < N_CHUNKS; k++) begin
            p = LEN_W'(k * CHUNK_DIGITS);
            if (p < len) begin
                left = len - p;
                n    = (left < LEN_W'(CHUNK_DIGITS)) ? left : LEN_W'(CHUNK_DIGITS);
                sh   = key >> ((left - n) * 4);
                acc  = acc ^ (sh[HASH_W-1:0] & hash_mask(n));
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* rtl/oaht_ram.sv */
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/oaht_mod.sv */
// ----------------------------------------------------------------------------
// oaht_mod
// Bit-serial remainder unit: hash value mod table size, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_mod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [oaht_pkg::HASH_W-1:0]   i_dividend,
    input  wire logic [oaht_pkg::SIZE_W-1:0]   i_divisor,
    output      logic                          o_done,
    output      logic [oaht_pkg::ADDR_W-1:0]   o_rem
);

    localparam int unsigned CNT_W = $clog2(oaht_pkg::HASH_W + 1);

    logic [oaht_pkg::HASH_W-1:0] r_dvd;
    logic [oaht_pkg::SIZE_W-1:0] r_rem;
    logic [oaht_pkg::SIZE_W-1:0] r_div;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [oaht_pkg::SIZE_W:0]   rem_sh;
    logic [oaht_pkg::SIZE_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[oaht_pkg::HASH_W-1]};
        rem_sub = (rem_sh >= {1'b0, r_div}) ? rem_sh - {1'b0, r_div} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(oaht_pkg::HASH_W);
            end else if (r_busy) begin
                r_rem <= rem_sub[oaht_pkg::SIZE_W-1:0];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[oaht_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

/* rtl/open_addressing_hash_table_core.sv */
// Clearing pass after reset writes every slot with tready low; config writes are taken.
// Insert/find: accept, hash, home slot mod (plus the step mod in double hashing), a RAM
//   read and a check per probed slot, then the output register.
// Total query: a read, check and advance per active slot, plus per stored key the hash/mod
//   work and a walk from its home slot.
// One item at a time; reset clears the table, size 1024, last-seven hash, linear probing.
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// Open-addressing hash table with linear or double-hash probing over one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [10:0]   i_cfg_wdata,
    input  wire logic          i_s_tvalid,
    output      logic          o_s_tready,
    // [63:0] key_value, [68:64] key_digits, [100:69] value_in, [103:101] zero
    input  wire logic [103:0]  i_s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]    i_s_tuser,
    output      logic          o_m_tvalid,
    input  wire logic          i_m_tready,
    // [31:0] value_out, [52:32] probe_count, [55:53] zero
    output      logic [55:0]   o_m_tdata,
    // [2:0] status
    output      logic [2:0]    o_m_tuser
);

    localparam int unsigned AW = oaht_pkg::ADDR_W;
    localparam int unsigned SW = oaht_pkg::SIZE_W;
    localparam int unsigned LW = oaht_pkg::LEN_W;
    localparam int unsigned KW = oaht_pkg::KEY_W;
    localparam int unsigned PW = oaht_pkg::PROBE_W;
    localparam logic [1:0] CFG_SIZE = 2'd0;
    localparam logic [1:0] CFG_HASH = 2'd1;
    localparam logic [1:0] CFG_MODE = 2'd2;
    localparam logic [PW-1:0] PROBE_MAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD1, S_MOD2, S_READ, S_CHECK,
        S_TREAD, S_TCHK, S_WALK, S_TNEXT, S_DONE
    } t_state;

    t_state r_state;
    logic [SW-1:0]  r_cfg_size;
    logic           r_hash_sel;
    logic           r_probe_mode;
    logic [AW-1:0]  r_clr;
    logic [SW-1:0]  r_count;
    oaht_pkg::t_req    r_req;
    oaht_pkg::t_status r_status;
    logic [KW-1:0]  r_key;
    logic [LW-1:0]  r_len;
    logic [oaht_pkg::VALUE_BITS-1:0] r_val;
    logic [oaht_pkg::HASH_W-1:0] r_sec;
    logic [AW-1:0]  r_home;
    logic [AW-1:0]  r_step;
    logic [AW-1:0]  r_idx;
    logic [SW-1:0]  r_n;
    logic [SW-1:0]  r_i;
    logic [PW-1:0]  r_total;
    logic [PW-1:0]  r_probes;
    logic [oaht_pkg::OUT_VAL_W-1:0] r_vout;
    logic           r_ovalid;
    logic [2:0]     r_ostatus;
    logic [oaht_pkg::OUT_VAL_W-1:0] r_ovalue;
    logic [PW-1:0]  r_oprobes;

    logic [SW-1:0]  size;
    logic [LW-1:0]  in_len;
    logic [oaht_pkg::HASH_W-1:0] h_tail, h_chunk, h_pri, h_sec;
    logic           mod_start, mod_done;
    logic [oaht_pkg::HASH_W-1:0] mod_dvd;
    logic [AW-1:0]  mod_rem;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    oaht_pkg::t_slot ram_wdata, ram_rdata;
    logic [SW-1:0]  nxt_sum;
    logic [AW-1:0]  nxt_idx;
    logic [SW-1:0]  visits;
    logic           key_match;
    logic [PW:0]    tot_sum;
    logic [SW-1:0]  i_inc;
    logic           accept;

    always_comb begin
        if (r_cfg_size == '0) begin
            size = SW'(1);
        end else if (r_cfg_size > SW'(oaht_pkg::TABLE_DEPTH)) begin
            size = SW'(oaht_pkg::TABLE_DEPTH);
        end else begin
            size = r_cfg_size;
        end
        in_len = (i_s_tdata[68:64] > LW'(oaht_pkg::KEY_DIGITS)) ?
                 LW'(oaht_pkg::KEY_DIGITS) : i_s_tdata[68:64];
        h_tail  = oaht_pkg::hash_tail(r_key, r_len);
        h_chunk = oaht_pkg::hash_chunks(r_key, r_len);
        h_pri   = r_hash_sel ? h_chunk : h_tail;
        h_sec   = r_hash_sel ? h_tail : h_chunk;
        nxt_sum = {1'b0, r_idx} + {1'b0, r_step};
        nxt_idx = (nxt_sum >= size) ? AW'(nxt_sum - size) : nxt_sum[AW-1:0];
        visits  = r_n + SW'(1);
        key_match = (ram_rdata.len == r_len) && (ram_rdata.key == r_key);
        tot_sum = {1'b0, r_total} + (PW + 1)'(r_n);
        i_inc   = r_i + SW'(1);
        accept  = i_s_tvalid && o_s_tready;
        mod_start = (r_state == S_HASH) ||
                    (r_state == S_MOD1 && mod_done && r_probe_mode);
        mod_dvd   = (r_state == S_HASH) ? h_pri : r_sec;
        ram_raddr = (r_state == S_TREAD) ? r_i[AW-1:0] : r_idx;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_CHECK) && (r_req == oaht_pkg::REQ_INSERT) &&
                        !ram_rdata.used;
            ram_waddr = r_idx;
            ram_wdata = {1'b1, r_len, r_key, r_val};
        end
    end

    oaht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    oaht_ram #(
        .WIDTH ($bits(oaht_pkg::t_slot)),
        .DEPTH (oaht_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_count      <= '0;
            r_cfg_size   <= SW'(oaht_pkg::TABLE_DEPTH);
            r_hash_sel   <= 1'b0;
            r_probe_mode <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE: r_cfg_size   <= i_cfg_wdata;
                    CFG_HASH: r_hash_sel   <= i_cfg_wdata[0];
                    CFG_MODE: r_probe_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            // S_DONE reloads the output register itself
            if (r_ovalid && i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= oaht_pkg::t_req'(i_s_tuser);
                        r_len    <= in_len;
                        r_key    <= i_s_tdata[KW-1:0] & oaht_pkg::key_mask(in_len);
                        r_val    <= i_s_tdata[69 +: oaht_pkg::VALUE_BITS];
                        r_status <= oaht_pkg::ST_OK;
                        r_probes <= '0;
                        r_vout   <= '0;
                        r_n      <= '0;
                        r_i      <= '0;
                        r_total  <= '0;
                        case (oaht_pkg::t_req'(i_s_tuser))
                            oaht_pkg::REQ_INSERT: begin
                                if (in_len == '0) begin
                                    r_status <= oaht_pkg::ST_EMPTY_KEY;
                                    r_state  <= S_DONE;
                                end else if (r_count >= size) begin
                                    r_status <= oaht_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_HASH;
                                end
                            end
                            oaht_pkg::REQ_FIND: begin
                                if (in_len == '0) begin
                                    r_status <= oaht_pkg::ST_EMPTY_KEY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_HASH;
                                end
                            end
                            oaht_pkg::REQ_TOTAL: r_state <= S_TREAD;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_HASH: begin
                    r_sec   <= h_sec;
                    r_state <= S_MOD1;
                end
                S_MOD1: begin
                    if (mod_done) begin
                        r_home <= mod_rem;
                        r_idx  <= mod_rem;
                        r_n    <= '0;
                        if (r_probe_mode) begin
                            r_state <= S_MOD2;
                        end else begin
                            r_step  <= AW'(1);
                            r_state <= (r_req == oaht_pkg::REQ_TOTAL) ? S_WALK : S_READ;
                        end
                    end
                end
                S_MOD2: begin
                    if (mod_done) begin
                        r_step  <= (mod_rem == '0) ? AW'(1) : mod_rem;
                        r_state <= (r_req == oaht_pkg::REQ_TOTAL) ? S_WALK : S_READ;
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_req == oaht_pkg::REQ_FIND) begin
                        r_probes <= PW'(visits);
                    end
                    if (!ram_rdata.used) begin
                        if (r_req == oaht_pkg::REQ_INSERT) begin
                            r_status <= oaht_pkg::ST_OK;
                            r_count  <= r_count + SW'(1);
                        end else begin
                            r_status <= oaht_pkg::ST_NOT_FOUND;
                        end
                        r_state <= S_DONE;
                    end else if (key_match) begin
                        if (r_req == oaht_pkg::REQ_INSERT) begin
                            r_status <= oaht_pkg::ST_DUPLICATE;
                        end else begin
                            r_status <= oaht_pkg::ST_OK;
                            r_vout   <= oaht_pkg::OUT_VAL_W'(ram_rdata.value);
                        end
                        r_state <= S_DONE;
                    end else if (nxt_idx == r_home || visits >= size) begin
                        r_status <= (r_req == oaht_pkg::REQ_INSERT) ?
                                    oaht_pkg::ST_NO_INSERT : oaht_pkg::ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= nxt_idx;
                        r_n     <= visits;
                        r_state <= S_READ;
                    end
                end
                S_TREAD: r_state <= S_TCHK;
                S_TCHK: begin
                    if (ram_rdata.used) begin
                        r_key   <= ram_rdata.key;
                        r_len   <= ram_rdata.len;
                        r_state <= S_HASH;
                    end else begin
                        r_state <= S_TNEXT;
                    end
                end
                S_WALK: begin
                    if ({1'b0, r_idx} != r_i && r_n < size) begin
                        r_idx <= nxt_idx;
                        r_n   <= visits;
                    end else begin
                        r_total <= (tot_sum > {1'b0, PROBE_MAX}) ? PROBE_MAX : tot_sum[PW-1:0];
                        r_state <= S_TNEXT;
                    end
                end
                S_TNEXT: begin
                    r_i <= i_inc;
                    if (i_inc >= size) begin
                        r_probes <= r_total;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_TREAD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_ovalue  <= r_vout;
                        r_oprobes <= r_probes;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = {3'b000, r_oprobes, r_ovalue};

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= oaht_pkg::ST_NOT_FOUND)
        else $error("result status out of range");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> $past(r_state) == S_READ)
        else $error("slot check without a RAM read");

    a_idx_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> {1'b0, r_idx} < size)
        else $error("probe index beyond active size");

    a_mod_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> {1'b0, mod_rem} < size)
        else $error("remainder not below table size");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && r_state == S_CHECK |=> r_count == $past(r_count) + SW'(1))
        else $error("stored count not advanced on insert");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the open-addressing hash table core. A directed
// table walks the empty-key, duplicate and not-found codes and edge keys;
// random phases change size, hash and probing mode while inserts, finds and
// totals stream under random backpressure, checked against a behavioral table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int unsigned CLK_HALF  = 6;
    localparam int unsigned LIMIT     = 12000000;
    localparam int unsigned REG_SIZE  = 0;
    localparam int unsigned REG_HASH  = 1;
    localparam int unsigned REG_PROBE = 2;
    localparam logic [20:0] PROBE_SAT = 21'h1FFFFF;

    typedef struct {
        oaht_pkg::t_status status;
        logic [31:0]       value;
        logic [20:0]       probes;
    } t_answer;

    typedef struct {
        oaht_pkg::t_req req;
        logic [63:0]    key;
        logic [4:0]     digits;
        logic [31:0]    value;
        bit             typed;
        t_answer        ans;
    } t_row;

    typedef struct {
        logic [63:0] key;
        logic [4:0]  digits;
    } t_key;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [10:0]   cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [103:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [55:0]   m_tdata;
    logic [2:0]    m_tuser;

    open_addressing_hash_table_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Behavioral copy of the table and its registers
    logic [10:0]  tbl_size_reg = 11'd1024;
    bit           tbl_xor_hash = 1'b0;
    bit           tbl_double   = 1'b0;
    bit           tbl_used  [oaht_pkg::TABLE_DEPTH];
    logic [63:0]  tbl_key   [oaht_pkg::TABLE_DEPTH];
    logic [4:0]   tbl_len   [oaht_pkg::TABLE_DEPTH];
    logic [31:0]  tbl_value [oaht_pkg::TABLE_DEPTH];
    int unsigned  tbl_count = 0;

    t_answer      pending_answers[$];
    t_key         key_pool[$];
    int unsigned  error_count = 0;
    int unsigned  results_seen = 0;
    int unsigned  items_sent = 0;
    int unsigned  status_hits[8];
    int unsigned  cycle_count = 0;
    int unsigned  tx_idle_pct = 21;
    int unsigned  rx_idle_pct = 69;
    int unsigned  rx_hold_left = 0;
    bit           rx_hold_done = 1'b0;

    function automatic logic [63:0] digit_bits(input int unsigned n);
        if (n >= 16) return '1;
        return (64'd1 << (4 * n)) - 64'd1;
    endfunction

    function automatic logic [63:0] tail_hash(input logic [63:0] key, input int unsigned len);
        return key & digit_bits(len < 7 ? len : 7);
    endfunction

    function automatic logic [63:0] xor_hash(input logic [63:0] key, input int unsigned len);
        logic [63:0] acc;
        int unsigned n;
        acc = '0;
        for (int unsigned p = 0; p < len; p += 7) begin
            n = (len - p < 7) ? len - p : 7;
            acc ^= (key >> (4 * (len - p - n))) & digit_bits(n);
        end
        return acc;
    endfunction

    function automatic int unsigned live_size();
        if (tbl_size_reg == 0) return 1;
        if (tbl_size_reg > oaht_pkg::TABLE_DEPTH) return oaht_pkg::TABLE_DEPTH;
        return tbl_size_reg;
    endfunction

    function automatic void probe_start(input logic [63:0] key, input int unsigned len,
                                        input int unsigned size,
                                        output int unsigned home, output int unsigned stride);
        logic [63:0] a;
        logic [63:0] b;
        a = tail_hash(key, len);
        b = xor_hash(key, len);
        home = int'((tbl_xor_hash ? b : a) % size);
        stride = 1;
        if (tbl_double) begin
            stride = int'((tbl_xor_hash ? a : b) % size);
            if (stride == 0) stride = 1;
        end
    endfunction

    function automatic t_answer table_request(input oaht_pkg::t_req req,
                                              input logic [63:0] key_in,
                                              input logic [4:0] digits,
                                              input logic [31:0] value);
        t_answer     ans;
        int unsigned size;
        int unsigned len;
        int unsigned home;
        int unsigned stride;
        int unsigned idx;
        int unsigned walk;
        logic [63:0] key;
        longint unsigned total;
        ans = '{oaht_pkg::ST_OK, 32'd0, 21'd0};
        size = live_size();
        len = (digits > 16) ? 16 : digits;
        key = key_in & digit_bits(len);
        case (req)
            oaht_pkg::REQ_INSERT: begin
                if (len == 0) ans.status = oaht_pkg::ST_EMPTY_KEY;
                else if (tbl_count >= size) ans.status = oaht_pkg::ST_FULL;
                else begin
                    probe_start(key, len, size, home, stride);
                    idx = home;
                    ans.status = oaht_pkg::ST_NO_INSERT;
                    for (int unsigned n = 0; n < size; n++) begin
                        if (!tbl_used[idx]) begin
                            tbl_used[idx] = 1'b1;
                            tbl_key[idx] = key;
                            tbl_len[idx] = 5'(len);
                            tbl_value[idx] = value;
                            tbl_count++;
                            ans.status = oaht_pkg::ST_OK;
                            break;
                        end
                        if (tbl_len[idx] == len && tbl_key[idx] == key) begin
                            ans.status = oaht_pkg::ST_DUPLICATE;
                            break;
                        end
                        idx = (idx + stride) % size;
                        if (idx == home) break;
                    end
                end
            end
            oaht_pkg::REQ_FIND: begin
                if (len == 0) ans.status = oaht_pkg::ST_EMPTY_KEY;
                else begin
                    probe_start(key, len, size, home, stride);
                    idx = home;
                    ans.status = oaht_pkg::ST_NOT_FOUND;
                    for (int unsigned n = 0; n < size; n++) begin
                        ans.probes++;
                        if (!tbl_used[idx]) break;
                        if (tbl_len[idx] == len && tbl_key[idx] == key) begin
                            ans.status = oaht_pkg::ST_OK;
                            ans.value = tbl_value[idx];
                            break;
                        end
                        idx = (idx + stride) % size;
                        if (idx == home) break;
                    end
                end
            end
            oaht_pkg::REQ_TOTAL: begin
                total = 0;
                for (int unsigned i = 0; i < size; i++) begin
                    if (!tbl_used[i]) continue;
                    probe_start(tbl_key[i], tbl_len[i], size, home, stride);
                    idx = home;
                    walk = 0;
                    // keys stranded by a size change add the full size
                    while (idx != i && walk < size) begin
                        idx = (idx + stride) % size;
                        walk++;
                    end
                    total += walk;
                    if (total > PROBE_SAT) total = PROBE_SAT;
                end
                ans.probes = 21'(total);
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] mismatch %s: got %0h expected %0h (result %0d)",
                 $realtime, what, got, want, results_seen);
        error_count++;
    endtask

    task automatic write_reg(input int unsigned index, input logic [10:0] data);
        cfg_we <= 1'b1;
        cfg_index <= 2'(index);
        cfg_wdata <= data;
        @(posedge i_clk);
        case (index)
            REG_SIZE:  tbl_size_reg = data;
            REG_HASH:  tbl_xor_hash = data[0];
            REG_PROBE: tbl_double = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [10:0] size, input bit xor_sel, input bit dbl);
        write_reg(REG_SIZE, size);
        write_reg(REG_HASH, 11'(xor_sel));
        write_reg(REG_PROBE, 11'(dbl));
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Called right after a rising edge; returns right after the accepting edge
    task automatic send_request(input oaht_pkg::t_req req, input logic [63:0] key,
                                input logic [4:0] digits, input logic [31:0] value,
                                input bit typed, input t_answer typed_ans);
        t_answer ans;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, value, digits, key};
        s_tuser <= req;
        do @(posedge i_clk); while (!s_tready);
        ans = table_request(req, key, digits, value);
        pending_answers.push_back(typed ? typed_ans : ans);
        items_sent++;
        if (items_sent == 433) begin
            tx_idle_pct = 69;
            rx_idle_pct = 21;
        end else if (items_sent == 866) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic random_request(input int unsigned total_pct);
        oaht_pkg::t_req req;
        t_key           k;
        int unsigned    r;
        bit             reuse;
        r = $urandom_range(99);
        if (r < total_pct) req = oaht_pkg::REQ_TOTAL;
        else if (r < total_pct + 2) req = oaht_pkg::REQ_NONE;
        else if (r < 52) req = oaht_pkg::REQ_INSERT;
        else req = oaht_pkg::REQ_FIND;
        reuse = key_pool.size() > 0 &&
                $urandom_range(99) < ((req == oaht_pkg::REQ_FIND) ? 70 : 25);
        if (reuse) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
            k.key = {$urandom, $urandom};
            r = $urandom_range(99);
            if (r < 5) k.digits = 5'd0;
            else if (r < 10) k.digits = 5'($urandom_range(31, 17));
            else k.digits = 5'($urandom_range(16, 1));
            if (req == oaht_pkg::REQ_INSERT) begin
                key_pool.push_back(k);
                if (key_pool.size() > 64) void'(key_pool.pop_front());
            end
        end
        send_request(req, k.key, k.digits, $urandom, 1'b0,
                     '{oaht_pkg::ST_OK, 32'd0, 21'd0});
    endtask

    // Drop tvalid at once so the last request is not offered twice
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver: check each transfer, then pick the next tready
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            status_hits[m_tuser]++;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result status", m_tuser, 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("value_out", m_tdata[31:0], want.value);
                if (m_tdata[52:32] !== want.probes)
                    report_mismatch("probe_count", m_tdata[52:32], want.probes);
            end
        end
        if (!rx_hold_done && results_seen == 150) begin
            rx_hold_done = 1'b1;
            rx_hold_left = 600;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_answers.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    t_row directed[] = '{
        '{oaht_pkg::REQ_FIND,   64'h1,   5'd1,  32'h0, 1'b1,
          '{oaht_pkg::ST_NOT_FOUND, 32'h0, 21'd1}},
        '{oaht_pkg::REQ_TOTAL,  64'h0,   5'd0,  32'h0, 1'b1,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_INSERT, 64'hDEAD, 5'd0, 32'h5, 1'b1,
          '{oaht_pkg::ST_EMPTY_KEY, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'hDEAD, 5'd0, 32'h0, 1'b1,
          '{oaht_pkg::ST_EMPTY_KEY, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1'b1,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 32'hFFFF_FFFF, 1'b1,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 32'h1234, 1'b1,
          '{oaht_pkg::ST_DUPLICATE, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 32'h0, 1'b1,
          '{oaht_pkg::ST_OK, 32'hFFFF_FFFF, 21'd1}},
        '{oaht_pkg::REQ_INSERT, 64'h5,   5'd1,  32'h0, 1'b1,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        // same value with a leading zero is a different key
        '{oaht_pkg::REQ_INSERT, 64'h5,   5'd2,  32'h1, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'h5,   5'd2,  32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'h5,   5'd1,  32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        // stray bits above the digit count
        '{oaht_pkg::REQ_INSERT, 64'hABCD_0000_0000_0123, 5'd3, 32'h7, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'h123, 5'd3,  32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        // digit count above 16 acts as 16
        '{oaht_pkg::REQ_INSERT, 64'h0123_4567_89AB_CDEF, 5'd31, 32'h8000_0000, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'h0123_4567_89AB_CDEF, 5'd16, 32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'h0,   5'd16, 32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_FIND,   64'h7,   5'd5,  32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}},
        '{oaht_pkg::REQ_TOTAL,  64'h0,   5'd0,  32'h0, 1'b0,
          '{oaht_pkg::ST_OK, 32'h0, 21'd0}}
    };

    initial begin
        int unsigned phase_size [9] = '{0, 8, 12, 50, 97, 1024, 2047, 1, 2046};
        bit          phase_xor  [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 1};
        bit          phase_dbl  [9] = '{0, 1, 1, 0, 1, 1, 0, 0, 1};
        int unsigned phase_len  [9] = '{40, 120, 150, 200, 300, 200, 150, 60, 60};
        int unsigned phase_tot  [9] = '{5, 6, 6, 5, 4, 1, 1, 5, 1};
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        foreach (status_hits[i]) status_hits[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_request(directed[i].req, directed[i].key, directed[i].digits,
                         directed[i].value, directed[i].typed, directed[i].ans);
        drain();

        for (int p = 0; p < 9; p++) begin
            configure(11'(phase_size[p]), phase_xor[p], phase_dbl[p]);
            repeat (phase_len[p]) random_request(phase_tot[p]);
            drain();
        end

        $display("Sent %0d requests over 9 register settings, %0d results checked",
                 items_sent, results_seen);
        $display("Status mix ok/empty/dup/full/noins/notfound: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
